// ===== hdl/ewc_pkg.sv =====
// ----------------------------------------------------------------------------
// ewc_pkg: shared types and constants for the energy-weighted centroid block
// Field widths, word layouts, axis codes and the control word between the
// sequencer and the accumulator.
// ----------------------------------------------------------------------------
package ewc_pkg;

  localparam int ENERGY_BITS   = 20;
  localparam int POSITION_BITS = 16;
  localparam int SUM_BITS      = 24;

  // Weighted sums: full-scale total times full-scale position, plus sign
  localparam int WSUM_BITS = SUM_BITS + POSITION_BITS + 1;
  // Common width for comparing a hit energy against the remaining room
  localparam int EXT_BITS  = (ENERGY_BITS > SUM_BITS) ? ENERGY_BITS : SUM_BITS;

  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic                            start_cluster;
    logic [ENERGY_BITS-1:0]          energy;
    logic signed [POSITION_BITS-1:0] pos_x;
    logic signed [POSITION_BITS-1:0] pos_y;
    logic signed [POSITION_BITS-1:0] pos_z;
  } in_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]             total_energy;
    logic signed [POSITION_BITS-1:0] centroid_x;
    logic signed [POSITION_BITS-1:0] centroid_y;
    logic signed [POSITION_BITS-1:0] centroid_z;
    logic                            saturated;
  } out_t;

  typedef struct packed {
    logic  load;
    logic  mac;
    axis_t axis;
  } acc_ctrl_t;

endpackage

// ===== hdl/ewc_div.sv =====
// ----------------------------------------------------------------------------
// ewc_div: iterative signed-by-unsigned divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// The quotient magnitude is known to fit POSITION_BITS, so only that many
// steps are run. A zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module ewc_div (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  input  logic signed [ewc_pkg::WSUM_BITS-1:0]     dividend,
  input  logic [ewc_pkg::SUM_BITS-1:0]             divisor,
  output logic                                     done,
  output logic signed [ewc_pkg::POSITION_BITS-1:0] quotient
);
  import ewc_pkg::*;

  localparam int COUNT_BITS = $clog2(POSITION_BITS + 1);

  logic                     busy;
  logic [COUNT_BITS-1:0]    count;
  logic [SUM_BITS-1:0]      rem;
  logic [SUM_BITS-1:0]      divisor_r;
  logic [POSITION_BITS-1:0] qbits;
  logic                     neg;

  logic [WSUM_BITS-1:0]     mag_in;
  logic [SUM_BITS:0]        trial;
  logic                     fits;
  logic [SUM_BITS:0]        rem_step;
  logic [POSITION_BITS-1:0] q_step;

  assign mag_in   = dividend[WSUM_BITS-1] ? WSUM_BITS'(-dividend) : WSUM_BITS'(dividend);
  assign trial    = {rem, qbits[POSITION_BITS-1]};
  assign fits     = trial >= {1'b0, divisor_r};
  assign rem_step = fits ? (trial - {1'b0, divisor_r}) : trial;
  assign q_step   = {qbits[POSITION_BITS-2:0], fits};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (divisor == '0) begin
          done     <= 1'b1;
          quotient <= '0;
        end else begin
          busy      <= 1'b1;
          count     <= COUNT_BITS'(POSITION_BITS);
          neg       <= dividend[WSUM_BITS-1];
          divisor_r <= divisor;
          // high part is already below the divisor
          rem       <= mag_in[WSUM_BITS-2:POSITION_BITS];
          qbits     <= mag_in[POSITION_BITS-1:0];
        end
      end else if (busy) begin
        rem   <= rem_step[SUM_BITS-1:0];
        qbits <= q_step;
        count <= count - COUNT_BITS'(1);
        if (count == COUNT_BITS'(1)) begin
          busy     <= 1'b0;
          done     <= 1'b1;
          quotient <= neg ? $signed(-q_step) : $signed(q_step);
        end
      end
    end
  end

endmodule

// ===== hdl/ewc_acc.sv =====
// ----------------------------------------------------------------------------
// ewc_acc: energy and weighted position accumulators
// Clips the hit energy to the room left below full scale, keeps the total and
// the saturation flag, and adds energy*position per axis through one shared
// multiplier with a registered product.
// ----------------------------------------------------------------------------
module ewc_acc (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ewc_pkg::acc_ctrl_t                   ctrl,
  input  ewc_pkg::in_t                         in_word,
  output logic [ewc_pkg::SUM_BITS-1:0]         energy_sum,
  output logic                                 saturation_flag,
  output logic signed [ewc_pkg::WSUM_BITS-1:0] wsum_x,
  output logic signed [ewc_pkg::WSUM_BITS-1:0] wsum_y,
  output logic signed [ewc_pkg::WSUM_BITS-1:0] wsum_z
);
  import ewc_pkg::*;

  logic [SUM_BITS-1:0]             eff;
  logic signed [POSITION_BITS-1:0] pos_x;
  logic signed [POSITION_BITS-1:0] pos_y;
  logic signed [POSITION_BITS-1:0] pos_z;
  logic signed [WSUM_BITS-1:0]     prod;
  axis_t                           prod_axis;
  logic                            prod_valid;

  logic [SUM_BITS-1:0]             base_energy;
  logic [SUM_BITS-1:0]             room;
  logic [EXT_BITS-1:0]             energy_ext;
  logic                            clip;
  logic [SUM_BITS-1:0]             eff_next;
  logic signed [SUM_BITS:0]        eff_s;
  logic signed [POSITION_BITS-1:0] pos_sel;
  logic signed [WSUM_BITS-1:0]     prod_next;

  assign base_energy = in_word.start_cluster ? '0 : energy_sum;
  assign room        = SUM_MAX - base_energy;
  assign energy_ext  = EXT_BITS'(in_word.energy);
  assign clip        = energy_ext >= EXT_BITS'(room);
  assign eff_next    = clip ? room : energy_ext[SUM_BITS-1:0];

  assign eff_s = {1'b0, eff};

  always_comb begin
    case (ctrl.axis)
      AXIS_X:  pos_sel = pos_x;
      AXIS_Y:  pos_sel = pos_y;
      AXIS_Z:  pos_sel = pos_z;
      default: pos_sel = '0;
    endcase
  end

  assign prod_next = eff_s * pos_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_sum      <= '0;
      saturation_flag <= 1'b0;
      wsum_x          <= '0;
      wsum_y          <= '0;
      wsum_z          <= '0;
      prod_valid      <= 1'b0;
    end else begin
      prod_valid <= ctrl.mac;
      if (ctrl.load) begin
        energy_sum      <= base_energy + eff_next;
        saturation_flag <= (saturation_flag & ~in_word.start_cluster) | clip;
        if (in_word.start_cluster) begin
          wsum_x <= '0;
          wsum_y <= '0;
          wsum_z <= '0;
        end
      end else if (prod_valid) begin
        case (prod_axis)
          AXIS_X:  wsum_x <= wsum_x + prod;
          AXIS_Y:  wsum_y <= wsum_y + prod;
          AXIS_Z:  wsum_z <= wsum_z + prod;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      eff   <= eff_next;
      pos_x <= in_word.pos_x;
      pos_y <= in_word.pos_y;
      pos_z <= in_word.pos_z;
    end
    if (ctrl.mac) begin
      prod      <= prod_next;
      prod_axis <= ctrl.axis;
    end
  end

endmodule

// ===== hdl/energy_weighted_centroid.sv =====
// ----------------------------------------------------------------------------
// energy_weighted_centroid: running energy-weighted centroid of one cluster
// Each input word adds a hit (or a merged cluster) to the accumulators and
// yields one output word with the total energy and the x, y, z centroid.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data, output out_valid/out_ready/out_data,
// words move when valid and ready are both high. start_cluster clears the
// accumulators before its own word is added.
// One word passes from acceptance to the output register in these steps: the
// word is taken, three products are formed on the shared multiplier, then
// one divide per axis runs on the shared bit-serial divider (POSITION_BITS
// steps plus start and hand over). With a zero total each divide ends right
// after its start, without running its steps. in_ready is high only while
// the sequencer is idle, so a new word is not taken until the last one has
// passed through the divides and reached the output register.
// The result sits in an output register; the next word is taken while it
// waits. If the receiver still stalls when the next result is ready, the
// sequencer holds that result until the register is free.
// Reset clears the sums, the flag and out_valid; in_ready is high from the
// first cycle after reset. Zero total energy gives a zero centroid.
// ----------------------------------------------------------------------------
module energy_weighted_centroid (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ewc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ewc_pkg::out_t out_data
);
  import ewc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_MAC      = 5'b00010,
    ST_DIV_GO   = 5'b00100,
    ST_DIV_WAIT = 5'b01000,
    ST_DONE     = 5'b10000
  } state_t;

  state_t state;
  axis_t  axis;
  axis_t  axis_next;

  logic signed [POSITION_BITS-1:0] cent_x;
  logic signed [POSITION_BITS-1:0] cent_y;
  logic signed [POSITION_BITS-1:0] cent_z;

  acc_ctrl_t                   acc_ctrl;
  logic [SUM_BITS-1:0]         energy_sum;
  logic                        saturation_flag;
  logic signed [WSUM_BITS-1:0] wsum_x;
  logic signed [WSUM_BITS-1:0] wsum_y;
  logic signed [WSUM_BITS-1:0] wsum_z;

  logic                            div_start;
  logic signed [WSUM_BITS-1:0]     div_dividend;
  logic                            div_done;
  logic signed [POSITION_BITS-1:0] div_quotient;

  assign in_ready      = (state == ST_IDLE);
  assign acc_ctrl.load = in_valid && in_ready;
  assign acc_ctrl.mac  = (state == ST_MAC);
  assign acc_ctrl.axis = axis;
  assign div_start     = (state == ST_DIV_GO);

  always_comb begin
    case (axis)
      AXIS_X:  axis_next = AXIS_Y;
      AXIS_Y:  axis_next = AXIS_Z;
      default: axis_next = AXIS_X;
    endcase
  end

  always_comb begin
    case (axis)
      AXIS_X:  div_dividend = wsum_x;
      AXIS_Y:  div_dividend = wsum_y;
      AXIS_Z:  div_dividend = wsum_z;
      default: div_dividend = '0;
    endcase
  end

  ewc_acc u_acc (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (acc_ctrl),
    .in_word         (in_data),
    .energy_sum      (energy_sum),
    .saturation_flag (saturation_flag),
    .wsum_x          (wsum_x),
    .wsum_y          (wsum_y),
    .wsum_z          (wsum_z)
  );

  ewc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (energy_sum),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= AXIS_X;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            axis  <= AXIS_X;
            state <= ST_MAC;
          end
        end
        ST_MAC: begin
          axis <= axis_next;
          if (axis == AXIS_Z) begin
            state <= ST_DIV_GO;
          end
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            case (axis)
              AXIS_X:  cent_x <= div_quotient;
              AXIS_Y:  cent_y <= div_quotient;
              default: cent_z <= div_quotient;
            endcase
            axis <= axis_next;
            state <= (axis == AXIS_Z) ? ST_DONE : ST_DIV_GO;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_data.total_energy <= energy_sum;
            out_data.centroid_x   <= cent_x;
            out_data.centroid_y   <= cent_y;
            out_data.centroid_z   <= cent_z;
            out_data.saturated    <= saturation_flag;
            out_valid             <= 1'b1;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
